// ----- design/cpc_pkg.sv -----
// ----------------------------------------------------------------------------
// cpc_pkg: shared types and constants
// Opcodes, register indexes, fixed field widths and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int OPCODE_W = 1;
  localparam int ROW_W    = 10;
  localparam int COL_W    = 6;
  localparam int DOSE_W   = 2;
  localparam int CORR_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 11;
  localparam int ROWS_REG_W = 11;
  localparam int COLS_REG_W = 7;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 2'd1;

  localparam logic signed [CORR_W-1:0] CORR_MAX = 16'sh7FFF;

  // scaled result is built from floor(2^32 c^2 / V), which fits 33 bits
  localparam int QUOT_W  = 33;
  localparam int RAD_W   = 34;
  localparam int ROOT_W  = 17;
  localparam int SQREM_W = 20;
  localparam int SQ_STEPS = 17;
  localparam int SQCNT_W  = 5;

  typedef struct packed {
    logic load_wr;
    logic query_start;
    logic acc_run;
    logic mul1;
    logic mul2;
    logic mul3;
    logic div_run;
    logic sqrt_init;
    logic sqrt_run;
    logic res_load;
    logic out_load;
  } cpc_cmd_t;

  typedef struct packed {
    logic special;
    logic acc_done;
    logic zero_var;
    logic div_done;
    logic sqrt_done;
  } cpc_status_t;

endpackage

// ----- design/cpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpc_ctrl: sequencing controller
// Walks a query through accumulate, multiply, divide and root phases and
// owns the input ready and the output valid.
// ----------------------------------------------------------------------------
module cpc_ctrl
  import cpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [OPCODE_W-1:0] in_opcode,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  cpc_status_t         sts,
  output cpc_cmd_t            cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_MUL1 = 4'd2;
  localparam logic [3:0] S_MUL2 = 4'd3;
  localparam logic [3:0] S_MUL3 = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SQRT = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.query_start = 1'b1;
            state_nxt = sts.special ? S_OUT : S_ACC;
          end
        end
      end
      S_ACC: begin
        cmd.acc_run = 1'b1;
        if (sts.acc_done) state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = sts.zero_var ? S_OUT : S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.sqrt_init = 1'b1;
          state_nxt = S_SQRT;
        end else begin
          cmd.div_run = 1'b1;
        end
      end
      S_SQRT: begin
        if (sts.sqrt_done) begin
          cmd.res_load = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.sqrt_run = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/cpc_dpath.sv -----
// ----------------------------------------------------------------------------
// cpc_dpath: sample store and arithmetic datapath
// Holds the dosage matrix and configuration, accumulates column sums, forms
// variance and covariance terms, then a restoring divide and a bit-pair
// square root give the scaled magnitude.
// ----------------------------------------------------------------------------
module cpc_dpath
  import cpc_pkg::*;
#(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cpc_cmd_t              cmd,
  output cpc_status_t           sts,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ROW_W-1:0]      in_row_index,
  input  logic [COL_W-1:0]      in_first_column,
  input  logic [COL_W-1:0]      in_second_column,
  input  logic [DOSE_W-1:0]     in_dosage,
  output logic signed [CORR_W-1:0] out_correlation,
  output logic                  out_degenerate
);

  localparam int VB    = VALUE_BITS;
  localparam int RB    = $clog2(MAX_ROWS + 1);
  localparam int CB    = $clog2(MAX_COLS + 1);
  localparam int RAB   = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = VB + RB;
  localparam int QW    = 2 * VB + RB;
  localparam int PW    = 2 * VB + 2 * RB;
  localparam int VW    = 2 * PW;
  localparam int XW    = VW + 32;
  localparam int DCW   = $clog2(XW + 1);

  // configuration, stored already clamped to the array size
  logic [RB-1:0] rows_r;
  logic [CB-1:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= RB'((1024 > MAX_ROWS) ? MAX_ROWS : 1024);
      cols_r <= CB'((64 > MAX_COLS) ? MAX_COLS : 64);
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS_IN_USE) begin
        rows_r <= (32'(cfg_data[ROWS_REG_W-1:0]) > 32'(MAX_ROWS)) ? RB'(MAX_ROWS)
                                                                 : RB'(cfg_data[ROWS_REG_W-1:0]);
      end else if (cfg_index == REG_COLS_IN_USE) begin
        cols_r <= (32'(cfg_data[COLS_REG_W-1:0]) > 32'(MAX_COLS)) ? CB'(MAX_COLS)
                                                                 : CB'(cfg_data[COLS_REG_W-1:0]);
      end
    end
  end

  // sample store: one write port, two registered read ports
  logic [VB-1:0] mem [DEPTH];
  logic [VB-1:0] rd_a_r, rd_b_r;
  logic [AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic          wr_en;

  logic [COL_W-1:0] ca_r, cb_r;
  logic [RB-1:0]    cnt_r;
  logic             rdv_r;
  logic             issue;

  assign wr_en = cmd.load_wr && (32'(in_row_index) < 32'(MAX_ROWS))
                 && (32'(in_first_column) < 32'(cols_r));
  assign wr_addr   = AW'(AW'(in_row_index) * AW'(MAX_COLS) + AW'(in_first_column));
  assign rd_addr_a = AW'(AW'(cnt_r[RAB-1:0]) * AW'(MAX_COLS) + AW'(ca_r));
  assign rd_addr_b = AW'(AW'(cnt_r[RAB-1:0]) * AW'(MAX_COLS) + AW'(cb_r));
  assign issue     = cmd.acc_run && (cnt_r != rows_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= VB'(in_dosage);
    rd_a_r <= mem[rd_addr_a];
    rd_b_r <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r <= 1'b0;
    end else begin
      rdv_r <= issue;
    end
  end

  // query setup and special cases
  logic oou, same;
  assign oou  = (32'(in_first_column) >= 32'(cols_r)) || (32'(in_second_column) >= 32'(cols_r));
  assign same = (in_first_column == in_second_column);

  // sums
  logic [SW-1:0] si_r, sj_r;
  logic [QW-1:0] qi_r, qj_r, p_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      ca_r  <= in_first_column;
      cb_r  <= in_second_column;
      cnt_r <= '0;
      si_r  <= '0;
      sj_r  <= '0;
      qi_r  <= '0;
      qj_r  <= '0;
      p_r   <= '0;
    end else begin
      if (issue) cnt_r <= cnt_r + RB'(1);
      if (rdv_r) begin
        si_r <= si_r + SW'(rd_a_r);
        sj_r <= sj_r + SW'(rd_b_r);
        qi_r <= qi_r + QW'(rd_a_r) * QW'(rd_a_r);
        qj_r <= qj_r + QW'(rd_b_r) * QW'(rd_b_r);
        p_r  <= p_r + QW'(rd_a_r) * QW'(rd_b_r);
      end
    end
  end

  // variance and covariance terms
  logic [PW-1:0] t1_r, t2_r, t3_r, t4_r, t5_r, t6_r;
  logic [PW-1:0] vi_r, vj_r, mag_r;
  logic          neg_r;
  logic signed [PW:0] cov;

  assign cov = $signed({1'b0, t5_r}) - $signed({1'b0, t6_r});

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      t1_r <= PW'(PW'(rows_r) * PW'(qi_r));
      t2_r <= PW'(PW'(si_r) * PW'(si_r));
      t3_r <= PW'(PW'(rows_r) * PW'(qj_r));
      t4_r <= PW'(PW'(sj_r) * PW'(sj_r));
      t5_r <= PW'(PW'(rows_r) * PW'(p_r));
      t6_r <= PW'(PW'(si_r) * PW'(sj_r));
    end
    if (cmd.mul2) begin
      vi_r  <= t1_r - t2_r;
      vj_r  <= t3_r - t4_r;
      neg_r <= cov[PW];
      mag_r <= cov[PW] ? PW'(-cov) : PW'(cov);
    end
  end

  assign sts.zero_var = (vi_r == '0) || (vj_r == '0);
  assign sts.special  = oou || same;

  // restoring divide of c^2 * 2^32 by vi*vj, one quotient bit a cycle
  logic [VW-1:0]     v_r, rem_r;
  logic [XW-1:0]     x_r;
  logic [QUOT_W-1:0] q_r;
  logic [DCW-1:0]    dcnt_r;
  logic [VW:0]       dsh;
  logic              dge;

  assign dsh = {rem_r, x_r[XW-1]};
  assign dge = dsh >= {1'b0, v_r};

  always_ff @(posedge clk) begin
    if (cmd.mul3) begin
      v_r    <= VW'(vi_r) * VW'(vj_r);
      x_r    <= {VW'(mag_r) * VW'(mag_r), 32'b0};
      rem_r  <= '0;
      q_r    <= '0;
      dcnt_r <= DCW'(XW);
    end else if (cmd.div_run) begin
      rem_r  <= dge ? VW'(dsh - {1'b0, v_r}) : VW'(dsh);
      q_r    <= {q_r[QUOT_W-2:0], dge};
      x_r    <= {x_r[XW-2:0], 1'b0};
      dcnt_r <= dcnt_r - DCW'(1);
    end
  end

  assign sts.div_done = (dcnt_r == '0);

  // integer square root, two radicand bits a cycle
  logic [RAD_W-1:0]   d_r;
  logic [ROOT_W-1:0]  root_r;
  logic [SQREM_W-1:0] srem_r, s2, trial;
  logic [SQCNT_W-1:0] scnt_r;
  logic               sge;

  assign s2    = {srem_r[SQREM_W-3:0], d_r[RAD_W-1:RAD_W-2]};
  assign trial = SQREM_W'({root_r, 2'b01});
  assign sge   = s2 >= trial;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      d_r    <= RAD_W'(q_r);
      root_r <= '0;
      srem_r <= '0;
      scnt_r <= SQCNT_W'(SQ_STEPS);
    end else if (cmd.sqrt_run) begin
      d_r    <= {d_r[RAD_W-3:0], 2'b00};
      srem_r <= sge ? (s2 - trial) : s2;
      root_r <= {root_r[ROOT_W-2:0], sge};
      scnt_r <= scnt_r - SQCNT_W'(1);
    end
  end

  assign sts.sqrt_done = (scnt_r == '0);
  assign sts.acc_done  = !rdv_r && (cnt_r == rows_r);

  // largest k with (2k-1)^2 <= floor(2^32 c^2 / V) is ceil(root / 2)
  logic [ROOT_W:0]   kk;
  logic [ROOT_W-1:0] k;
  assign kk = (ROOT_W+1)'(root_r) + (ROOT_W+1)'(1);
  assign k  = kk[ROOT_W:1];

  logic signed [CORR_W-1:0] res_corr_r;
  logic                     res_deg_r;

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      res_deg_r  <= oou;
      res_corr_r <= (!oou && same) ? CORR_MAX : '0;
    end else if (cmd.mul3 && sts.zero_var) begin
      res_deg_r  <= 1'b1;
      res_corr_r <= '0;
    end else if (cmd.res_load) begin
      res_deg_r <= 1'b0;
      if (neg_r) res_corr_r <= CORR_W'(-k);
      else if (k > ROOT_W'(CORR_MAX)) res_corr_r <= CORR_MAX;
      else res_corr_r <= CORR_W'(k);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_correlation <= res_corr_r;
      out_degenerate  <= res_deg_r;
    end
  end

endmodule

// ----- design/column_pearson_correlation.sv -----
// ----------------------------------------------------------------------------
// column_pearson_correlation: Pearson correlation of two stored columns
// Dosage matrix store with a query engine returning Q1.15 correlation.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per item. Opcode load writes in_dosage at (row, first
//           column) and is accepted with no result word. Opcode
//           query returns one word on out_* with the correlation of the two
//           named columns and a degenerate flag.
//   cfg_* : register writes (0 rows in use, 1 columns in use), always ready;
//           write only while the block is idle.
// Sequence: a query over the rows in use reads the store, forms the
//   products and differences, runs the restoring divide and the square
//   root, then loads the output word; a next item is accepted only once
//   that word is loaded. A constant column skips the divide and root;
//   an unused or repeated column goes straight to the output load.
// Reset: synchronous active low; the store is not cleared and every entry
//   must be written before a query reads it.
// Stall: a result word holds on out_* until out_ready; a further query
//   is still taken; its output load waits for the register to free up.
// ----------------------------------------------------------------------------
module column_pearson_correlation
  import cpc_pkg::*;
#(
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_COLS   = 64,
  parameter int VALUE_BITS = 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [OPCODE_W-1:0]      in_opcode,
  input  logic [ROW_W-1:0]         in_row_index,
  input  logic [COL_W-1:0]         in_first_column,
  input  logic [COL_W-1:0]         in_second_column,
  input  logic [DOSE_W-1:0]        in_dosage,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CORR_W-1:0] out_correlation,
  output logic                     out_degenerate,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data
);

  cpc_cmd_t    cmd;
  cpc_status_t sts;

  assign cfg_ready = 1'b1;

  cpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpc_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_row_index     (in_row_index),
    .in_first_column  (in_first_column),
    .in_second_column (in_second_column),
    .in_dosage        (in_dosage),
    .out_correlation  (out_correlation),
    .out_degenerate   (out_degenerate)
  );

endmodule

// ----- design/cpc_checker.sv -----
// ----------------------------------------------------------------------------
// cpc_checker: port level checks
// Watches the top level ports for result word behaviour.
// ----------------------------------------------------------------------------
module cpc_checker
  import cpc_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [OPCODE_W-1:0]      in_opcode,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [CORR_W-1:0] out_correlation,
  input logic                     out_degenerate
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_correlation)
                                && $stable(out_degenerate))
    else $error("result word changed while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_correlation == '0)
    else $error("degenerate word with nonzero correlation");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_opcode == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load produced a result word");

endmodule

bind column_pearson_correlation cpc_checker u_cpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_opcode       (in_opcode),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_correlation (out_correlation),
  .out_degenerate  (out_degenerate)
);
